/* hdl/versioned_slot_allocator_macros.svh */
// Assertion macros for the checker file of the slot allocator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef VERSIONED_SLOT_ALLOCATOR_MACROS_SVH
`define VERSIONED_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vsa_pkg.sv */
package vsa_pkg;

  // Default sizing of the slot table.
  localparam int SLOTS_DEF        = 32;
  localparam int VERSION_BITS_DEF = 31;

  // Fixed field widths of the channels.
  localparam int SLOT_IDX_W  = 5;
  localparam int VER_OUT_W   = 31;
  localparam int COUNT_OUT_W = 6;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } vsa_status_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } vsa_state_t;

  // One input item.
  typedef struct packed {
    logic                  opcode;
    logic [SLOT_IDX_W-1:0] slot_index;
  } vsa_in_t;

  // One result item.
  typedef struct packed {
    vsa_status_t            status;
    logic [SLOT_IDX_W-1:0]  slot;
    logic [VER_OUT_W-1:0]   slot_version;
    logic [COUNT_OUT_W-1:0] live_count;
  } vsa_out_t;

endpackage

/* hdl/vsa_ram.sv */
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/vsa_hint.sv */
module vsa_hint #(
  parameter int SLOTS = 32
) (
  input  logic [SLOTS-1:0]         live,
  output logic                     found,
  output logic [$clog2(SLOTS)-1:0] idx
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEAVES = 1 << SLOT_W;

  // Binary tree of find-first-zero nodes; the left child wins.
  logic                fnd_lv [SLOT_W+1][LEAVES];
  logic [SLOT_W-1:0]   idx_lv [SLOT_W+1][LEAVES];

  genvar l, j;

  // Leaves: a slot is a candidate when it is free; padding leaves never are.
  for (j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < SLOTS) begin : g_real
      assign fnd_lv[0][j] = ~live[j];
    end else begin : g_pad
      assign fnd_lv[0][j] = 1'b0;
    end
    assign idx_lv[0][j] = '0;
  end

  // Each level adds one index bit, set when the right child supplies the slot.
  for (l = 0; l < SLOT_W; l++) begin : g_level
    localparam logic [SLOT_W-1:0] LVL_BIT = SLOT_W'(1 << l);
    for (j = 0; j < (LEAVES >> (l + 1)); j++) begin : g_node
      assign fnd_lv[l+1][j] = fnd_lv[l][2*j] | fnd_lv[l][2*j+1];
      assign idx_lv[l+1][j] = fnd_lv[l][2*j] ? idx_lv[l][2*j]
                                             : (idx_lv[l][2*j+1] | LVL_BIT);
    end
  end

  assign found = fnd_lv[SLOT_W][0];
  assign idx   = idx_lv[SLOT_W][0];

endmodule

/* hdl/versioned_slot_allocator.sv */
// Versioned slot allocator.
// Input channel (in_valid / in_stall / in_item): opcode 0 allocates the lowest
// free slot, opcode 1 frees in_item.slot_index. Result channel (out_valid /
// out_stall / out_item): one result item per input item, carrying status,
// slot, the slot's version and the live count after the operation.
// An item accepted at a clock edge reads the version memory at that edge; in
// S_EXEC, once the result register is free, the version is modified, written
// back and the result register loaded. The block takes no new item until
// that write-back, since the version memory read is registered ahead of it.
// A finished result may wait in the output register while the next item is
// accepted and read; that item's write-back waits until the result is taken.
// After reset every slot is free, the live count is zero and the version
// memory is cleared by a pass over every slot, during which in_stall is high.
// While out_stall is high the result holds unchanged on out_item.
module versioned_slot_allocator import vsa_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int VERSION_BITS = VERSION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  vsa_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output vsa_out_t out_item
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  vsa_state_t state_r, state_nxt;

  logic [SLOT_W-1:0]       clr_cnt_r;
  logic [SLOTS-1:0]        live_r;
  logic [CNT_W-1:0]        total_r;

  // Item in flight between read and write-back.
  logic                    op_r;
  vsa_status_t             status_r;
  logic [SLOT_W-1:0]       addr_r;
  logic [SLOT_IDX_W-1:0]   idx_r;

  logic                    out_valid_r;
  vsa_out_t                out_item_r, out_item_nxt;

  logic                    hint_found;
  logic [SLOT_W-1:0]       hint_idx;

  logic                    in_acc;
  logic                    out_free;
  logic                    clearing;
  logic                    exec_done;
  logic                    idx_in_range;
  logic [SLOT_W-1:0]       idx_addr;
  logic [SLOT_W-1:0]       acc_addr;
  vsa_status_t             acc_status;

  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [VERSION_BITS-1:0] ram_wdata;
  logic [VERSION_BITS-1:0] rd_ver;
  logic [VERSION_BITS-1:0] new_ver;

  // Lowest free slot from the live bits.
  vsa_hint #(
    .SLOTS(SLOTS)
  ) u_hint (
    .live  (live_r),
    .found (hint_found),
    .idx   (hint_idx)
  );

  // Per-slot version memory.
  vsa_ram #(
    .WIDTH(VERSION_BITS),
    .DEPTH(SLOTS)
  ) u_ver_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (acc_addr),
    .rdata (rd_ver)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    clearing  = 1'b0;
    exec_done = 1'b0;
    unique case (state_r)
      S_CLEAR: clearing = 1'b1;
      S_IDLE:  in_stall = 1'b0;
      S_EXEC:  exec_done = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Decode of an item at acceptance: memory address and outcome.
  assign idx_in_range = int'(in_item.slot_index) < SLOTS;
  assign idx_addr     = SLOT_W'(in_item.slot_index);

  always_comb begin
    if (in_item.opcode == OP_ALLOC) begin
      acc_addr   = hint_idx;
      acc_status = hint_found ? ST_OK : ST_FULL;
    end else begin
      acc_addr   = idx_addr;
      acc_status = (idx_in_range && live_r[idx_addr]) ? ST_OK : ST_NOT_LIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_item.opcode;
      status_r <= acc_status;
      addr_r   <= acc_addr;
      idx_r    <= in_item.slot_index;
    end
  end

  // Version bump; the all-ones version wraps to one.
  assign new_ver = (rd_ver == '1) ? VERSION_BITS'(1) : rd_ver + VERSION_BITS'(1);

  // Memory write: clearing pass, or the bumped version of an allocate.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = new_ver;
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (exec_done && op_r == OP_ALLOC && status_r == ST_OK) begin
      ram_we = 1'b1;
    end
  end

  // Result of the item in flight.
  always_comb begin
    out_item_nxt.status       = status_r;
    out_item_nxt.slot         = '0;
    out_item_nxt.slot_version = '0;
    out_item_nxt.live_count   = COUNT_OUT_W'(total_r);
    unique case (status_r)
      ST_OK: begin
        out_item_nxt.slot = SLOT_IDX_W'(addr_r);
        if (op_r == OP_ALLOC) begin
          out_item_nxt.slot_version = VER_OUT_W'(new_ver);
          out_item_nxt.live_count   = COUNT_OUT_W'(total_r + 1'b1);
        end else begin
          out_item_nxt.slot_version = VER_OUT_W'(rd_ver);
          out_item_nxt.live_count   = COUNT_OUT_W'(total_r - 1'b1);
        end
      end
      ST_FULL: begin
        out_item_nxt.slot = '0;
      end
      ST_NOT_LIVE: begin
        out_item_nxt.slot = idx_r;
      end
      default: out_item_nxt.slot = '0;
    endcase
  end

  // Live bits and live count change at write-back of a successful item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      total_r <= '0;
    end else if (exec_done && status_r == ST_OK) begin
      if (op_r == OP_ALLOC) begin
        live_r[addr_r] <= 1'b1;
        total_r        <= total_r + 1'b1;
      end else begin
        live_r[addr_r] <= 1'b0;
        total_r        <= total_r - 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/vsa_checker.sv */
`include "versioned_slot_allocator_macros.svh"

module vsa_checker import vsa_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int VERSION_BITS = VERSION_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input vsa_out_t out_item
);

  // A stalled result stays offered and unchanged.
  `VSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")

  // A full table reports neither a slot nor a version.
  `VSA_ASSERT_NOW(a_full_zero, out_valid && out_item.status == ST_FULL, out_item.slot == '0 && out_item.slot_version == '0, "full result item carries a slot or version")

  // A rejected free reports no version.
  `VSA_ASSERT_NOW(a_not_live_zero, out_valid && out_item.status == ST_NOT_LIVE, out_item.slot_version == '0, "rejected free item carries a version")

  // A live slot never has version zero when the version fits the field.
  `VSA_ASSERT_NOW(a_ok_version, (VERSION_BITS <= VER_OUT_W) && out_valid && out_item.status == ST_OK, out_item.slot_version != '0, "successful item carries version zero")

  // The live count never exceeds the table size when it fits the field.
  `VSA_ASSERT_NOW(a_count_range, (SLOTS < (1 << COUNT_OUT_W)) && out_valid, int'(out_item.live_count) <= SLOTS, "live count above table size")

endmodule

bind versioned_slot_allocator vsa_checker #(
  .SLOTS        (SLOTS),
  .VERSION_BITS (VERSION_BITS)
) u_vsa_checker (.*);
